### rtl/core/sid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_pkg: shared definitions of the signed integer divider
// Operand width, stream widths, sequencer codes and the status group that
// the iterative divide core reports to the top level.
// ----------------------------------------------------------------------------
package sid_pkg;

	localparam int WIDTH = 32;

	// Stream payload widths, rounded up to whole bytes.
	localparam int IN_TDATA_W  = ((2 * WIDTH + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((WIDTH + 7) / 8) * 8;

	// Iteration counter runs from WIDTH-1 down to zero.
	localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	// Largest positive quotient, used when the result overflows.
	localparam logic [WIDTH-1:0] SAT_MAX = {1'b0, {(WIDTH - 1){1'b1}}};

	// Sequencer state codes.
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_FIX  = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} sid_stat_t;

endpackage

### rtl/core/signed_integer_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_divider: signed WIDTH-bit divider with saturation
// Sign handling, sequencing and the output register around an iterative
// radix-2 restoring divide core.
// ----------------------------------------------------------------------------
// The block divides a signed dividend by a signed divisor and returns the
// quotient truncated toward zero; no remainder is given. Both operands are
// turned into unsigned magnitudes first, so the most negative value divides
// correctly. Dividing the most negative value by minus one saturates the
// quotient to the most positive value. A zero divisor returns a quotient of
// zero with the div_by_zero flag in m_tuser set. The block takes one item at
// a time: s_tready is high only while the sequencer is idle. An item with a
// nonzero divisor goes through the load state, where the magnitudes are
// formed, the shared subtractor of the divide core, the sign fix-up and the
// hand-off into the output register; a new item is taken only once that
// item has left the sequencer. A zero divisor skips the divide core. The
// result sits in an output register, so the next item is accepted while an
// earlier result still waits for m_tready; the sign fix-up then holds until
// that register is free.
// ----------------------------------------------------------------------------
module signed_integer_divider
	import sid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Input items.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // dividend, divisor
	// Result items.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // quotient
	output logic                   m_tuser    // div_by_zero
);

	logic [1:0]       state_q;
	logic [WIDTH-1:0] a_q;
	logic [WIDTH-1:0] b_q;
	logic             neg_q;
	logic             dz_q;

	logic             out_valid_q;
	logic [WIDTH-1:0] out_quot_q;
	logic             out_dz_q;

	logic             in_fire;
	logic             out_free;
	logic             core_start;
	logic [WIDTH-1:0] mag_a;
	logic [WIDTH-1:0] mag_b;
	logic [WIDTH-1:0] core_quot;
	logic [WIDTH-1:0] fixed_quot;
	sid_stat_t        core_stat;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// Magnitudes as unsigned WIDTH-bit values; the most negative number maps
	// to 2**(WIDTH-1), which still fits.
	assign mag_a = a_q[WIDTH-1] ? (~a_q + 1'b1) : a_q;
	assign mag_b = b_q[WIDTH-1] ? (~b_q + 1'b1) : b_q;

	assign core_start = (state_q == ST_LOAD) && (b_q != '0) && !core_stat.busy;

	sid_divcore u_divcore (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (core_start),
		.dividend (mag_a),
		.divisor  (mag_b),
		.quotient (core_quot),
		.stat     (core_stat)
	);

	// Sign fix-up. With equal signs, a magnitude with its top bit set can only
	// come from the most negative value over minus one and saturates.
	always_comb begin
		priority if (dz_q) begin
			fixed_quot = '0;
		end else if (neg_q) begin
			fixed_quot = ~core_quot + 1'b1;
		end else if (core_quot[WIDTH-1]) begin
			fixed_quot = SAT_MAX;
		end else begin
			fixed_quot = core_quot;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (b_q == '0) begin
						state_q <= ST_FIX;
					end else if (core_start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (core_stat.done) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand capture.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			a_q <= s_tdata[WIDTH-1:0];
			b_q <= s_tdata[2*WIDTH-1:WIDTH];
		end
		if (state_q == ST_LOAD) begin
			neg_q <= a_q[WIDTH-1] ^ b_q[WIDTH-1];
			dz_q  <= (b_q == '0);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIX) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIX) && out_free) begin
			out_quot_q <= fixed_quot;
			out_dz_q   <= dz_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_quot_q);
	assign m_tuser  = out_dz_q;

endmodule

### rtl/core/sid_divcore.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_divcore: iterative unsigned restoring divider
// One shared subtractor produces one quotient bit per cycle, WIDTH bits in all.
// ----------------------------------------------------------------------------
module sid_divcore
	import sid_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient,
	output sid_stat_t        stat
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [WIDTH:0]   rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] den_q;

	logic [WIDTH:0]   rem_shift;
	logic [WIDTH+1:0] diff;

	// Bring down the next dividend bit and try to take the divisor out.
	assign rem_shift = {rem_q[WIDTH-1:0], quo_q[WIDTH-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			if (!diff[WIDTH+1]) begin
				rem_q <= diff[WIDTH:0];
			end else begin
				rem_q <= rem_shift;
			end
			quo_q <= {quo_q[WIDTH-2:0], ~diff[WIDTH+1]};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### tb/sv/signed_integer_divider_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_divider_checker: quotient predictor and result comparator
// Watches both stream channels of the divider, works out the expected
// quotient and divide-by-zero flag for every accepted item, and compares
// each accepted result with the oldest one still waiting.
// ----------------------------------------------------------------------------
module signed_integer_divider_checker
	import sid_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // dividend, divisor
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,   // quotient
	input  logic                   m_tuser,   // div_by_zero
	output int                     errors,
	output int                     pending,
	output int                     results,
	output int                     zero_divs,
	output int                     saturations
);

	typedef struct packed {
		logic [WIDTH-1:0] quotient;
		logic             div_by_zero;
		logic             saturated;
	} quotient_t;

	quotient_t quotients_due[$];

	// Division on magnitudes one bit wider than the operands, so the most
	// negative value has a magnitude of its own.
	function automatic quotient_t divide_signed(input logic [WIDTH-1:0] dvd,
						    input logic [WIDTH-1:0] dvs);
		quotient_t  r;
		logic       neg_a;
		logic       neg_b;
		logic [WIDTH:0] mag_a;
		logic [WIDTH:0] mag_b;
		logic [WIDTH:0] q;
		r = '0;
		if (dvs == '0) begin
			r.div_by_zero = 1'b1;
			return r;
		end
		neg_a = dvd[WIDTH-1];
		neg_b = dvs[WIDTH-1];
		mag_a = neg_a ? -{dvd[WIDTH-1], dvd} : {1'b0, dvd};
		mag_b = neg_b ? -{dvs[WIDTH-1], dvs} : {1'b0, dvs};
		q = mag_a / mag_b;
		if (neg_a != neg_b) begin
			r.quotient = -q[WIDTH-1:0];
		end else if (q > {1'b0, SAT_MAX}) begin
			r.quotient  = SAT_MAX;
			r.saturated = 1'b1;
		end else begin
			r.quotient = q[WIDTH-1:0];
		end
		return r;
	endfunction

	initial begin
		errors      = 0;
		pending     = 0;
		results     = 0;
		zero_divs   = 0;
		saturations = 0;
	end

	// The result side is handled first: a result leaving in the same cycle
	// as an item enters always belongs to an older item.
	always @(posedge clk) begin
		quotient_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results++;
				if (quotients_due.size() == 0) begin
					$error("result with no expectation waiting: quotient %0d, div_by_zero %0b",
					       $signed(m_tdata[WIDTH-1:0]), m_tuser);
					errors++;
				end else begin
					want = quotients_due.pop_front();
					if (m_tdata[WIDTH-1:0] !== want.quotient) begin
						$error("quotient: expected %0d, got %0d",
						       $signed(want.quotient), $signed(m_tdata[WIDTH-1:0]));
						errors++;
					end
					if (m_tuser !== want.div_by_zero) begin
						$error("div_by_zero: expected %0b, got %0b",
						       want.div_by_zero, m_tuser);
						errors++;
					end
					if (want.div_by_zero)
						zero_divs++;
					if (want.saturated)
						saturations++;
				end
			end
			if (s_tvalid && s_tready)
				quotients_due.push_back(divide_signed(s_tdata[WIDTH-1:0],
								       s_tdata[2*WIDTH-1:WIDTH]));
			pending = quotients_due.size();
		end
	end

endmodule

### tb/sv/signed_integer_divider_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_divider_tb: stream-level test of the signed divider
// Sends directed corner divisions and then random ones through four idling
// phases, with one long output stall, and leaves all checking to the
// checker instance that sits beside the block.
// ----------------------------------------------------------------------------
module signed_integer_divider_tb;
	import sid_pkg::*;

	// Operand corners.
	localparam logic [WIDTH-1:0] MOST_NEG  = {1'b1, {(WIDTH - 1){1'b0}}};
	localparam logic [WIDTH-1:0] MOST_POS  = SAT_MAX;
	localparam logic [WIDTH-1:0] MINUS_ONE = '1;

	// Each phase gets roughly a quarter of the random items.
	localparam int RANDOM_PER_PHASE = 460;
	// Cycles the receiver refuses results while the sender keeps pushing.
	localparam int HOLD_CYCLES      = 400;
	// Cycles without any handshake before the run is declared hung. The
	// longest quiet stretch of a correct run is the hold above.
	localparam int QUIET_LIMIT      = 3000;
	localparam int DRAIN_CYCLES     = 50;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // dividend, divisor
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // quotient
	logic                   m_tuser;   // div_by_zero

	int errors;
	int pending;
	int results;
	int zero_divs;
	int saturations;

	// Idling odds in percent, changed from phase to phase.
	int  idle_pct;
	int  stall_pct;
	// Raised by the stimulus to ask the receiver for a long hold-off.
	bit  hold_req;
	int  quiet_cycles;

	signed_integer_divider dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	signed_integer_divider_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.errors      (errors),
		.pending     (pending),
		.results     (results),
		.zero_divs   (zero_divs),
		.saturations (saturations)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// The reset is applied once and released on a falling edge.
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Hang detection: any accepted item on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("No handshake for %0d cycles, %0d results outstanding.",
					 QUIET_LIMIT, pending);
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Receiver. Normally it stalls at random; on request it holds m_tready
	// low for a long stretch so that the output register fills up, the sign
	// fix-up holds and s_tready drops.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Offers one item and returns on the falling edge after its acceptance.
	// Valid stays high into the next item unless an idle gap is drawn.
	task automatic offer_division(input logic [WIDTH-1:0] dividend,
				      input logic [WIDTH-1:0] divisor);
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= IN_TDATA_W'({divisor, dividend});
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	function automatic logic [WIDTH-1:0] boundary_value();
		case ($urandom_range(0, 5))
			0: return MOST_NEG;
			1: return MOST_POS;
			2: return MINUS_ONE;
			3: return '0;
			4: return WIDTH'(1);
			default: return MOST_NEG + 1'b1;
		endcase
	endfunction

	function automatic logic [WIDTH-1:0] any_value();
		return WIDTH'({$urandom, $urandom});
	endfunction

	function automatic logic [WIDTH-1:0] near_zero(input int span);
		int v;
		v = int'($urandom_range(0, 2 * span)) - span;
		return WIDTH'(v);
	endfunction

	// A mix of operand shapes: wide random values, small values where
	// quotients are easy to get wrong by one, divisors of every size so
	// that quotients of every length occur, zero divisors, and corners.
	task automatic random_divisions(input int count);
		logic [WIDTH-1:0] dividend;
		logic [WIDTH-1:0] divisor;
		int               shape;
		repeat (count) begin
			shape = $urandom_range(0, 99);
			if (shape < 35) begin
				dividend = any_value();
				divisor  = any_value();
			end else if (shape < 55) begin
				dividend = near_zero(64);
				divisor  = near_zero(64);
			end else if (shape < 68) begin
				dividend = any_value();
				divisor  = near_zero(8);
			end else if (shape < 82) begin
				dividend = any_value();
				divisor  = WIDTH'($signed(any_value()) >>> $urandom_range(0, WIDTH - 1));
			end else if (shape < 89) begin
				dividend = any_value();
				divisor  = '0;
			end else if (shape < 95) begin
				dividend = boundary_value();
				divisor  = boundary_value();
			end else begin
				dividend = ($urandom_range(0, 1) != 0) ? boundary_value() : any_value();
				divisor  = ($urandom_range(0, 1) != 0) ? boundary_value() : near_zero(3);
			end
			offer_division(dividend, divisor);
		end
	endtask

	localparam int N_CORNERS = 22;

	// Corner divisions: overflow, most negative and most positive operands,
	// zero dividends, zero divisors, and all four sign combinations with a
	// remainder so that truncation toward zero shows.
	logic [WIDTH-1:0] corner_dividend [N_CORNERS] = '{
		MOST_NEG, MOST_NEG, MOST_NEG, MOST_NEG, MOST_POS, MOST_POS,
		MOST_POS, MOST_POS, '0, '0, WIDTH'(42), MOST_NEG,
		'0, MINUS_ONE, WIDTH'(7), WIDTH'(-7), WIDTH'(7), WIDTH'(-7),
		WIDTH'(1), MINUS_ONE, MOST_NEG, WIDTH'(100)
	};
	logic [WIDTH-1:0] corner_divisor [N_CORNERS] = '{
		MINUS_ONE, WIDTH'(1), MOST_NEG, MOST_POS, MINUS_ONE, MOST_NEG,
		MOST_POS, WIDTH'(1), WIDTH'(5), MINUS_ONE, '0, '0,
		'0, '0, WIDTH'(2), WIDTH'(2), WIDTH'(-2), WIDTH'(-2),
		MOST_POS, MOST_NEG, WIDTH'(2), WIDTH'(-7)
	};

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		idle_pct  = 0;
		stall_pct = 0;
		hold_req  = 1'b0;
		@(posedge arst_n);
		@(negedge clk);

		// Phase one: back-to-back items and a receiver that never stalls at random.
		for (int i = 0; i < N_CORNERS; i++)
			offer_division(corner_dividend[i], corner_divisor[i]);
		// The receiver now holds off while items keep coming.
		hold_req = 1'b1;
		random_divisions(RANDOM_PER_PHASE);

		// Phase two: the sender idles often.
		idle_pct  = 45;
		stall_pct = 0;
		random_divisions(RANDOM_PER_PHASE);

		// Phase three: the receiver stalls often.
		idle_pct  = 0;
		stall_pct = 45;
		random_divisions(RANDOM_PER_PHASE);

		// Phase four: both sides hesitate.
		idle_pct  = 36;
		stall_pct = 36;
		random_divisions(RANDOM_PER_PHASE);

		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d quotients, %0d of them with a zero divisor and %0d saturated.",
			 results, zero_divs, saturations);
		$display("Idling covered free flow, sender gaps, receiver stalls, both, and a long hold.");
		if (errors == 0 && pending == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
